FILE: rtl/mfd_pkg.sv
// Shared types and constants of the MQTT frame delimiter.
`default_nettype none
package mfd_pkg;

	localparam int MAX_LENGTH_BYTES = 4;
	localparam int LEN_HOLD_DEPTH   = 4;
	localparam int LEN_W            = 28;
	localparam int CMD_DEPTH        = 2;
	localparam int OUT_DEPTH        = 2;

	localparam logic [7:0] PINGREQ  = 8'hc0;
	localparam logic [7:0] PINGRESP = 8'ha0;

	typedef logic [LEN_W-1:0] len_t;

	typedef enum logic [1:0] {
		PH_HEAD,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_PING,
		CMD_FRAME,
		CMD_ERROR
	} cmd_kind_t;

	// Work item from the front to the back.
	typedef struct packed {
		cmd_kind_t                            kind;
		logic [7:0]                           data;
		logic                                 last;
		logic [LEN_HOLD_DEPTH-1:0][7:0]       len_bytes;
		logic [2:0]                           len_count;
		len_t                                 length;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       to_client;
		logic       first;
		logic       last;
		len_t       length;
		logic       status;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/mqtt_frame_delimiter_unit.sv
// Top level of the MQTT frame delimiter: front end, work queue, back end, result queue.
// The results of a byte reach the output side through the work queue, the back end and
// the result queue; further results of the same byte follow one per cycle while that queue has room.
// Throughput: one byte accepted per cycle while the work queue has room; the back end
// emits one result per cycle while the result queue has room, so a final length byte
// (up to five results) can hold full high when bytes arrive back to back.
// Reset: arst_n clears phase, length decode state and both queues at once; no sweep.
`default_nettype none
module mqtt_frame_delimiter_unit #(
	parameter int CMD_DEPTH = mfd_pkg::CMD_DEPTH,
	parameter int OUT_DEPTH = mfd_pkg::OUT_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte queue side
	input  wire logic        push,
	input  wire logic [7:0]  rx_byte,
	output logic             full,
	// result queue side
	input  wire logic        pop,
	output logic             empty,
	output logic [7:0]       out_byte,
	output logic             to_client,
	output logic             frame_first,
	output logic             frame_last,
	output logic [27:0]      frame_length,
	output logic             status
);

	// Front end to work queue.
	logic           accept;
	logic           cmd_push;
	mfd_pkg::cmd_t  cmd_in;
	logic           cmd_full;

	// Work queue to back end.
	mfd_pkg::cmd_t  cmd_head;
	logic           cmd_empty;
	logic           cmd_pop;

	// Back end to result queue.
	logic           res_push;
	mfd_pkg::res_t  res_in;
	logic           out_full;
	mfd_pkg::res_t  res_head;

	// Take a byte whenever the work queue can hold what it may cause.
	assign full   = cmd_full;
	assign accept = push && !cmd_full;

	// Classify bytes, decode remaining length, hand off at most one work item per byte.
	mfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Decouple the front from the back so a header burst stalls intake only once the work queue is full.
	mfd_fifo #(
		.WIDTH ($bits(mfd_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	// Expand header, length bytes, payload bytes and ping replies, and flag length errors.
	mfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Hold finished results until the consumer pops them.
	mfd_fifo #(
		.WIDTH ($bits(mfd_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (out_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign out_byte     = res_head.out_byte;
	assign to_client    = res_head.to_client;
	assign frame_first  = res_head.first;
	assign frame_last   = res_head.last;
	assign frame_length = res_head.length;
	assign status       = res_head.status;

endmodule
`default_nettype wire

FILE: rtl/mfd_fifo.sv
// Small register queue with push/full and pop/empty sides.
`default_nettype none
module mfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mfd_front.sv
// Front end: tracks the frame phase, decodes the length and issues work items.
`default_nettype none
module mfd_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  rx_byte,
	output logic             cmd_push,
	output mfd_pkg::cmd_t    cmd
);

	mfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      header_q, header_d;
	logic [7:0]      hold_q [mfd_pkg::LEN_HOLD_DEPTH];
	logic [2:0]      count_q, count_d;
	mfd_pkg::len_t   acc_q, acc_d;
	mfd_pkg::len_t   rem_q, rem_d;

	logic [1:0]      cnt;
	logic [2:0]      cnt_inc;
	mfd_pkg::len_t   grp;
	mfd_pkg::len_t   acc_sum;
	mfd_pkg::len_t   rem_dec;

	assign cnt     = count_q[1:0];
	assign cnt_inc = count_q + 3'd1;
	assign acc_sum = acc_q + grp;
	assign rem_dec = rem_q - 1'b1;

	// Place the 7-bit group at its weight.
	always_comb begin
		unique case (cnt)
			2'd0:    grp = mfd_pkg::len_t'(rx_byte[6:0]);
			2'd1:    grp = mfd_pkg::len_t'(rx_byte[6:0]) << 7;
			2'd2:    grp = mfd_pkg::len_t'(rx_byte[6:0]) << 14;
			default: grp = mfd_pkg::len_t'(rx_byte[6:0]) << 21;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		header_d = header_q;
		count_d  = count_q;
		acc_d    = acc_q;
		rem_d    = rem_q;
		cmd_push = 1'b0;
		cmd      = '0;
		for (int i = 0; i < mfd_pkg::LEN_HOLD_DEPTH; i++) begin
			cmd.len_bytes[i] = (cnt == 2'(i)) ? rx_byte : hold_q[i];
		end
		if (accept) begin
			unique case (phase_q)
				mfd_pkg::PH_LEN: begin
					count_d = cnt_inc;
					acc_d   = acc_sum;
					if (rx_byte[7]) begin
						if (cnt_inc >= 3'(mfd_pkg::MAX_LENGTH_BYTES)) begin
							cmd_push = 1'b1;
							cmd.kind = mfd_pkg::CMD_ERROR;
							phase_d  = mfd_pkg::PH_HEAD;
							count_d  = '0;
							acc_d    = '0;
							rem_d    = '0;
						end
					end else begin
						cmd_push = 1'b1;
						count_d  = '0;
						acc_d    = '0;
						if (acc_sum == '0 && header_q == mfd_pkg::PINGREQ) begin
							cmd.kind = mfd_pkg::CMD_PING;
							phase_d  = mfd_pkg::PH_HEAD;
						end else begin
							cmd.kind      = mfd_pkg::CMD_FRAME;
							cmd.data      = header_q;
							cmd.len_count = cnt_inc;
							cmd.length    = acc_sum;
							rem_d         = acc_sum;
							phase_d       = (acc_sum == '0) ? mfd_pkg::PH_HEAD
								: mfd_pkg::PH_DATA;
						end
					end
				end
				mfd_pkg::PH_DATA: begin
					cmd_push = 1'b1;
					cmd.kind = mfd_pkg::CMD_DATA;
					cmd.data = rx_byte;
					rem_d    = rem_dec;
					if (rem_dec == '0) begin
						cmd.last = 1'b1;
						phase_d  = mfd_pkg::PH_HEAD;
					end
				end
				default: begin
					header_d = rx_byte;
					count_d  = '0;
					acc_d    = '0;
					rem_d    = '0;
					phase_d  = mfd_pkg::PH_LEN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == mfd_pkg::PH_LEN) begin
			hold_q[cnt] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mfd_pkg::PH_HEAD;
			header_q <= '0;
			count_q  <= '0;
			acc_q    <= '0;
			rem_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			header_q <= header_d;
			count_q  <= count_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mfd_back.sv
// Back end: expands work items into results, one per cycle unless out_full.
`default_nettype none
module mfd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mfd_pkg::cmd_t cmd,
	input  wire logic          cmd_empty,
	output logic               cmd_pop,
	input  wire logic          out_full,
	output logic               res_push,
	output mfd_pkg::res_t      res
);

	logic [2:0] idx_q;
	logic [2:0] idx_m1;
	logic       go;
	logic       done;

	assign go     = !cmd_empty && !out_full;
	assign idx_m1 = idx_q - 3'd1;

	always_comb begin
		res  = '0;
		done = 1'b0;
		unique case (cmd.kind)
			mfd_pkg::CMD_DATA: begin
				res.out_byte = cmd.data;
				res.last     = cmd.last;
				done         = 1'b1;
			end
			mfd_pkg::CMD_ERROR: begin
				res.status = 1'b1;
				done       = 1'b1;
			end
			mfd_pkg::CMD_PING: begin
				res.to_client = 1'b1;
				if (idx_q == '0) begin
					res.out_byte = mfd_pkg::PINGRESP;
					res.first    = 1'b1;
				end else begin
					res.last = 1'b1;
					done     = 1'b1;
				end
			end
			default: begin
				if (idx_q == '0) begin
					res.out_byte = cmd.data;
					res.first    = 1'b1;
					res.length   = cmd.length;
				end else begin
					res.out_byte = cmd.len_bytes[idx_m1[1:0]];
					res.last     = (idx_q == cmd.len_count) && (cmd.length == '0);
				end
				done = (idx_q == cmd.len_count);
			end
		endcase
	end

	assign res_push = go;
	assign cmd_pop  = go && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (go) begin
			idx_q <= done ? '0 : idx_q + 3'd1;
		end
	end

endmodule
`default_nettype wire

FILE: dv/mqtt_frame_delimiter_unit_tb.sv
// Self-checking testbench for the MQTT frame delimiter unit.
`timescale 1ns / 1ps
module mqtt_frame_delimiter_unit_tb;

	// Frame predictor and store of the results still owed by the block.
	class frame_scoreboard;
		mfd_pkg::res_t   expected_q[$];
		mfd_pkg::phase_t phase;
		logic [7:0]      header_hold;
		logic [7:0]      len_bytes [mfd_pkg::MAX_LENGTH_BYTES];
		int unsigned     len_count;
		mfd_pkg::len_t   len_acc;
		mfd_pkg::len_t   payload_left;
		int unsigned     errors;

		function new();
			phase        = mfd_pkg::PH_HEAD;
			header_hold  = '0;
			len_count    = 0;
			len_acc      = '0;
			payload_left = '0;
			errors       = 0;
		endfunction

		function void add_result(logic [7:0] b, logic cli, logic first, logic last,
				mfd_pkg::len_t len, logic st);
			mfd_pkg::res_t r;
			r.out_byte  = b;
			r.to_client = cli;
			r.first     = first;
			r.last      = last;
			r.length    = len;
			r.status    = st;
			expected_q.push_back(r);
		endfunction

		// Advance the frame state by one accepted byte and queue its results.
		function void note_rx_byte(logic [7:0] b);
			int unsigned idx;
			logic        zero_len;
			case (phase)
			mfd_pkg::PH_LEN: begin
				idx            = len_count & 3;
				len_bytes[idx] = b;
				len_acc        = len_acc + (mfd_pkg::len_t'(b[6:0]) << (7 * idx));
				len_count      = idx + 1;
				if (b[7]) begin
					if (len_count >= mfd_pkg::MAX_LENGTH_BYTES) begin
						add_result(8'h00, 1'b0, 1'b0, 1'b0, '0, 1'b1);
						phase        = mfd_pkg::PH_HEAD;
						len_count    = 0;
						len_acc      = '0;
						payload_left = '0;
					end
				end else begin
					if (len_acc == '0 && header_hold == mfd_pkg::PINGREQ) begin
						add_result(mfd_pkg::PINGRESP, 1'b1, 1'b1, 1'b0, '0, 1'b0);
						add_result(8'h00, 1'b1, 1'b0, 1'b1, '0, 1'b0);
						phase = mfd_pkg::PH_HEAD;
					end else begin
						zero_len = (len_acc == '0);
						add_result(header_hold, 1'b0, 1'b1, 1'b0, len_acc, 1'b0);
						for (int i = 0; i < len_count; i++)
							add_result(len_bytes[i], 1'b0, 1'b0,
								(i + 1 == len_count) && zero_len, '0, 1'b0);
						payload_left = len_acc;
						phase        = zero_len ? mfd_pkg::PH_HEAD : mfd_pkg::PH_DATA;
					end
					len_count = 0;
					len_acc   = '0;
				end
			end
			mfd_pkg::PH_DATA: begin
				payload_left = payload_left - 1'b1;
				add_result(b, 1'b0, 1'b0, payload_left == '0, '0, 1'b0);
				if (payload_left == '0)
					phase = mfd_pkg::PH_HEAD;
			end
			default: begin
				header_hold  = b;
				len_count    = 0;
				len_acc      = '0;
				payload_left = '0;
				phase        = mfd_pkg::PH_LEN;
			end
			endcase
		endfunction

		function void compare_field(string name, logic [27:0] exp, logic [27:0] act);
			if (exp !== act) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check_result(mfd_pkg::res_t act);
			mfd_pkg::res_t exp;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h", $time, act);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			compare_field("out_byte", 28'(exp.out_byte), 28'(act.out_byte));
			compare_field("to_client", 28'(exp.to_client), 28'(act.to_client));
			compare_field("frame_first", 28'(exp.first), 28'(act.first));
			compare_field("frame_last", 28'(exp.last), 28'(act.last));
			compare_field("frame_length", exp.length, act.length);
			compare_field("status", 28'(exp.status), 28'(act.status));
		endfunction
	endclass

	// Directed byte stream, one frame per line; the last frame's payload has its own line.
	localparam int N_DIRECTED = 26;
	localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
		8'hc0, 8'h00,                       // ping request, answered to the client
		8'hc0, 8'h80, 8'h00,                // ping request with padded length
		8'h00, 8'h00,                       // zero-length frame to the backend
		8'h30, 8'h80, 8'h80, 8'h80, 8'h00,  // four length bytes, length zero
		8'hff, 8'h80, 8'hff, 8'hff, 8'hff,  // overlong length, four continued bytes
		8'hc0, 8'h01, 8'hab,                // ping header with payload: plain frame
		8'h32, 8'h81, 8'h80, 8'h80, 8'h00,  // four length bytes, length one
		8'h55                               // its payload byte
	};

	logic        clk;
	logic        arst_n;
	logic        push;
	logic [7:0]  rx_byte;
	logic        full;
	logic        pop;
	logic        empty;
	logic [7:0]  out_byte;
	logic        to_client;
	logic        frame_first;
	logic        frame_last;
	logic [27:0] frame_length;
	logic        status;

	frame_scoreboard sb;
	int unsigned     snd_idle_pct;
	int unsigned     rcv_idle_pct;
	int unsigned     bytes_sent;

	mqtt_frame_delimiter_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rx_byte      (rx_byte),
		.full         (full),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.to_client    (to_client),
		.frame_first  (frame_first),
		.frame_last   (frame_last),
		.frame_length (frame_length),
		.status       (status)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one byte from the falling edge on, idling at random first, and hold it
	// until a rising edge sees push high with full low.
	task automatic send_byte(input logic [7:0] b);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) >= snd_idle_pct)
				break;
			push = 1'b0;
		end
		push    = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		sb.note_rx_byte(b);
		bytes_sent++;
	endtask

	// Send a well-formed frame; pad the length field to n_len bytes if that is
	// longer than the shortest encoding.
	task automatic send_frame(input logic [7:0] hdr, input int unsigned len,
			input int unsigned n_len);
		int unsigned groups;
		logic [7:0]  lb;
		groups = 1;
		while (groups < mfd_pkg::MAX_LENGTH_BYTES && (len >> (7 * groups)) != 0)
			groups++;
		if (n_len > groups)
			groups = n_len;
		send_byte(hdr);
		for (int i = 0; i < groups; i++) begin
			lb    = 8'(len >> (7 * i));
			lb[7] = (i + 1 < groups);
			send_byte(lb);
		end
		repeat (len)
			send_byte(8'($urandom));
	endtask

	// Mix mostly well-formed frames with pings, empty frames and overlong
	// length fields until n more bytes have gone in.
	task automatic run_random(input int unsigned n);
		int unsigned target;
		int unsigned pick;
		int unsigned n_len;
		target = bytes_sent + n;
		while (bytes_sent < target) begin
			pick  = $urandom_range(99);
			n_len = ($urandom_range(3) == 0) ?
				$urandom_range(1, mfd_pkg::MAX_LENGTH_BYTES) : 1;
			if (pick < 10) begin
				send_frame(mfd_pkg::PINGREQ, 0, n_len);
			end else if (pick < 20) begin
				send_byte(8'($urandom));
				repeat (mfd_pkg::MAX_LENGTH_BYTES)
					send_byte(8'($urandom) | 8'h80);
			end else if (pick < 25) begin
				send_frame(8'($urandom), 0, n_len);
			end else if (pick < 28) begin
				send_frame(8'($urandom), $urandom_range(128, 160), n_len);
			end else begin
				send_frame(8'($urandom), $urandom_range(1, 24), n_len);
			end
		end
	endtask

	// Receiver: decide pop at each falling edge from the current stall rate.
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			pop = ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// Check every result transaction at the rising edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(mfd_pkg::res_t'{out_byte, to_client, frame_first,
				frame_last, frame_length, status});
	end

	initial begin
		sb           = new();
		push         = 1'b0;
		rx_byte      = 8'h00;
		arst_n       = 1'b0;
		bytes_sent   = 0;
		snd_idle_pct = 26;
		rcv_idle_pct = 73;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames, then random traffic under three idle mixes.
		foreach (DIRECTED[i])
			send_byte(DIRECTED[i]);
		run_random(60);
		snd_idle_pct = 73;
		rcv_idle_pct = 26;
		run_random(60);
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_random(60);
		@(negedge clk);
		push = 1'b0;

		// Drain, then give any stray result time to show up.
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("mqtt_frame_delimiter_unit_tb passed");
		end else begin
			$display("mqtt_frame_delimiter_unit_tb failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("mqtt_frame_delimiter_unit_tb failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/mfd_pkg.sv
rtl/mfd_fifo.sv
rtl/mfd_front.sv
rtl/mfd_back.sv
rtl/mqtt_frame_delimiter_unit.sv
dv/mqtt_frame_delimiter_unit_tb.sv
